### hw/rtl/satl_pkg.sv
package satl_pkg;

  localparam int LFSR_W = 16;

  typedef logic [LFSR_W-1:0] lfsr_t;

  localparam lfsr_t SEED_RESET = 16'd44257;

  // x^16+x^14+x^13+x^11+1, Fibonacci form, shifting right
  function automatic lfsr_t lfsr_next(input lfsr_t s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[LFSR_W-1:1]};
  endfunction

endpackage

### hw/rtl/set_assoc_tag_lookup_random_repl.sv
// Set-associative tag lookup with pseudo-random replacement.
//
// Input: a word is taken on address at each rising edge with start high and
// busy low. busy is always low: a new lookup may be issued every cycle.
// Output: done pulses for one cycle with hit, way and evicted_valid. The
// result of an access is registered in the s1 stage and then in the output
// registers; results come out in issue order, one per cycle at full rate.
// The receiver cannot stall the block.
// Pipeline: the s1 registers capture the access while the set's tag row is
// read from the tag RAM; the s1 stage then compares all ways in parallel,
// refills a victim way on a miss and registers the result. A one-entry write
// bypass covers a tag RAM read overlapping the previous access's same-set refill.
// Config: cfg_we/cfg_data load the replacement LFSR seed at once; write only
// while no lookup is in flight. The LFSR steps once per miss; its low bits
// pick the victim way.
// Reset: valid bits clear, LFSR returns to its default seed,
// pending results are dropped. Tag RAM contents are not cleared.
module set_assoc_tag_lookup_random_repl #(
  parameter int ADDR_BITS  = 32,
  parameter int SETS       = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] address,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic        hit,
  output logic [1:0]  way,
  output logic        evicted_valid
);

  localparam int AW       = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int LS_FLOOR = $clog2(LINE_BYTES * SETS + 1) - 1;
  localparam int TAG_W    = (AW - LS_FLOOR > 0) ? AW - LS_FLOOR : 1;
  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic             accept;
  logic [AW-1:0]    in_addr;
  logic [AW-1:0]    in_line;
  logic [SET_W-1:0] in_set;
  logic [TAG_W-1:0] in_tag;

  logic             s1_valid;
  logic [SET_W-1:0] s1_set;
  logic [TAG_W-1:0] s1_tag;

  logic [TAG_W-1:0] tag_mem [SETS][WAYS];
  logic [TAG_W-1:0] row_q   [WAYS];
  logic [TAG_W-1:0] row     [WAYS];
  logic [WAYS-1:0]  valid_q [SETS];

  logic             byp_valid;
  logic [SET_W-1:0] byp_set;
  logic [WAY_W-1:0] byp_way;
  logic [TAG_W-1:0] byp_tag;

  logic             s1_hit;
  logic [WAY_W-1:0] s1_hit_way;
  logic [WAY_W-1:0] victim;
  logic [WAY_W-1:0] way_sel;
  logic             wr_en;
  logic             s1_evict;

  satl_pkg::lfsr_t  lfsr_state;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // address split: offset | set | tag
  assign in_addr = address[AW-1:0];
  assign in_line = in_addr / LINE_BYTES;
  assign in_set  = SET_W'(in_line % SETS);
  assign in_tag  = TAG_W'(in_line / SETS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_set <= in_set;
      s1_tag <= in_tag;
    end
  end

  // tag RAM: one row read per cycle, one way written per cycle
  always_ff @(posedge clk) begin
    row_q <= tag_mem[in_set];
    if (wr_en) begin
      tag_mem[s1_set][victim] <= s1_tag;
    end
  end

  // refill that landed at the same edge as this row read
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= wr_en;
    end
    byp_set <= s1_set;
    byp_way <= victim;
    byp_tag <= s1_tag;
  end

  always_comb begin
    row = row_q;
    if (byp_valid && byp_set == s1_set) begin
      row[byp_way] = byp_tag;
    end
  end

  // lowest matching valid way wins
  always_comb begin
    s1_hit     = 1'b0;
    s1_hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_q[s1_set][w] && row[w] == s1_tag) begin
        s1_hit     = 1'b1;
        s1_hit_way = WAY_W'(w);
      end
    end
  end

  assign victim   = WAY_W'(lfsr_state % WAYS);
  assign wr_en    = s1_valid & ~s1_hit;
  assign s1_evict = valid_q[s1_set][victim];
  assign way_sel  = s1_hit ? s1_hit_way : victim;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SETS; i++) begin
        valid_q[i] <= '0;
      end
    end else if (wr_en) begin
      valid_q[s1_set][victim] <= 1'b1;
    end
  end

  satl_lfsr u_lfsr (
    .clk      (clk),
    .rst      (rst),
    .load     (cfg_we),
    .load_val (cfg_data),
    .step     (wr_en),
    .state    (lfsr_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    if (s1_valid) begin
      hit           <= s1_hit;
      way           <= 2'(way_sel);
      evicted_valid <= wr_en & s1_evict;
    end
  end

  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("accepted word produced no result");

  a_result_has_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result without an accepted word");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> !evicted_valid)
    else $error("eviction reported on a hit");

  a_refill_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> valid_q[$past(s1_set)][$past(victim)])
    else $error("refilled way not marked valid");

  a_lfsr_hold: assert property (@(posedge clk) disable iff (rst)
    !wr_en && !cfg_we |=> $stable(lfsr_state))
    else $error("LFSR moved without a miss or seed write");

endmodule

### hw/rtl/satl_lfsr.sv
module satl_lfsr (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  satl_pkg::lfsr_t load_val,
  input  logic          step,
  output satl_pkg::lfsr_t state
);

  satl_pkg::lfsr_t state_next;

  always_comb begin
    state_next = state;
    if (load) begin
      state_next = load_val;
    end else if (step) begin
      state_next = satl_pkg::lfsr_next(state);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= satl_pkg::SEED_RESET;
    end else begin
      state <= state_next;
    end
  end

endmodule
